@@ rtl/c3x3_pkg.sv @@
// Shared constants, types and helpers for the 3x3 multi-filter convolution layer.
// Used by the controller, the datapath and the top level; depends on nothing.
package c3x3_pkg;

    localparam int IMG_W   = 12;
    localparam int IMG_H   = 12;
    localparam int FILTERS = 16;
    localparam int TAPS    = 9;
    localparam int WEIGHTS = FILTERS * TAPS;
    localparam int COEFS   = WEIGHTS + FILTERS;

    localparam int COL_W  = $clog2(IMG_W);
    localparam int ROW_W  = $clog2(IMG_H);
    localparam int FILT_W = (FILTERS > 1) ? $clog2(FILTERS) : 1;
    localparam int TAP_W  = 4;

    localparam int PIX_W   = 8;
    localparam int WGT_W   = 16;
    localparam int BIAS_W  = 24;
    localparam int PROD_W  = WGT_W + PIX_W + 1;
    localparam int PSUM_W  = PROD_W + 2;
    localparam int CONV_W  = 32;
    localparam int TAG_W   = 4;

    // idx / 9 for idx < 256 as (idx * 57) >> 9
    localparam int Recip9      = 57;
    localparam int Recip9Shift = 9;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ISSUE
    } ctrl_state_t;

    typedef struct packed {
        logic              accept_pix;
        logic              accept_coef;
        logic              win_load;
        logic              issue;
        logic [FILT_W-1:0] filt;
        logic              last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic win_full;
        logic pipe_busy;
        logic adv;
    } dp_status_t;

    typedef struct packed {
        logic [FILT_W-1:0] filt;
        logic [TAG_W-1:0]  row;
        logic [TAG_W-1:0]  col;
        logic              last;
    } res_tag_t;

    function automatic logic [FILT_W-1:0] weight_filter(input logic [7:0] idx);
        logic [13:0] p;
        p = 14'(idx) * 14'(Recip9);
        return FILT_W'(p >> Recip9Shift);
    endfunction

    function automatic logic signed [WGT_W-1:0] sat_weight(
        input logic signed [BIAS_W-1:0] v
    );
        logic signed [BIAS_W-1:0] hi;
        logic signed [BIAS_W-1:0] lo;
        hi = BIAS_W'(32767);
        lo = -BIAS_W'(32768);
        if (v > hi)
        begin
            return WGT_W'(hi);
        end
        else if (v < lo)
        begin
            return WGT_W'(lo);
        end
        return WGT_W'(v);
    endfunction

endpackage

@@ rtl/c3x3_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module c3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/c3x3_ctrl.sv @@
// Controller: item acceptance and per-filter issue sequencing.
// Depends on c3x3_pkg; drives the datapath through ctrl_cmd_t.
module c3x3_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  c3x3_pkg::dp_status_t status,
    output c3x3_pkg::ctrl_cmd_t  cmd
);

    c3x3_pkg::ctrl_state_t          state_reg;
    c3x3_pkg::ctrl_state_t          state_next;
    logic [c3x3_pkg::FILT_W-1:0]    filt_reg;
    logic [c3x3_pkg::FILT_W-1:0]    filt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c3x3_pkg::ST_IDLE;
            filt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            filt_reg  <= filt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        filt_next  = filt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        cmd.filt   = filt_reg;
        cmd.last   = (filt_reg == c3x3_pkg::FILT_W'(c3x3_pkg::FILTERS - 1));
        case (state_reg)
            c3x3_pkg::ST_IDLE:
            begin
                in_stall = status.pipe_busy;
                if (in_valid && !status.pipe_busy)
                begin
                    if (kind)
                    begin
                        cmd.accept_coef = 1'b1;
                    end
                    else
                    begin
                        cmd.accept_pix = 1'b1;
                        state_next     = c3x3_pkg::ST_LOAD;
                    end
                end
            end
            c3x3_pkg::ST_LOAD:
            begin
                cmd.win_load = 1'b1;
                if (status.win_full)
                begin
                    state_next = c3x3_pkg::ST_ISSUE;
                    filt_next  = '0;
                end
                else
                begin
                    state_next = c3x3_pkg::ST_IDLE;
                end
            end
            c3x3_pkg::ST_ISSUE:
            begin
                if (status.adv)
                begin
                    cmd.issue = 1'b1;
                    if (cmd.last)
                    begin
                        state_next = c3x3_pkg::ST_IDLE;
                    end
                    else
                    begin
                        filt_next = filt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = c3x3_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/c3x3_dp.sv @@
// Datapath: line store, 3x3 window, coefficient stores, MAC pipeline, output register.
// Depends on c3x3_pkg and c3x3_ram; commanded by c3x3_ctrl.
module c3x3_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  c3x3_pkg::ctrl_cmd_t                  cmd,
    output c3x3_pkg::dp_status_t                 status,
    input  logic [c3x3_pkg::PIX_W-1:0]           pixel,
    input  logic [7:0]                           coef_index,
    input  logic signed [c3x3_pkg::BIAS_W-1:0]   coef_value,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [3:0]                           filter_index,
    output logic [3:0]                           out_row,
    output logic [3:0]                           out_col,
    output logic signed [c3x3_pkg::CONV_W-1:0]   conv_value,
    output logic                                 last
);

    localparam int PW = c3x3_pkg::PIX_W;

    logic [c3x3_pkg::COL_W-1:0]  col_reg;
    logic [c3x3_pkg::ROW_W-1:0]  row_reg;
    logic [c3x3_pkg::ROW_W-1:0]  row_m2;
    logic [c3x3_pkg::COL_W-1:0]  col_m2;
    logic [PW-1:0]               px_reg;
    logic [PW-1:0]               win_reg [3][3];
    logic [2*PW-1:0]             line_rd;
    logic [c3x3_pkg::TAG_W-1:0]  pos_row_reg;
    logic [c3x3_pkg::TAG_W-1:0]  pos_col_reg;

    logic                        adv;
    logic                        s1_v_reg;
    logic                        s2_v_reg;
    logic                        s3_v_reg;
    logic                        out_v_reg;
    c3x3_pkg::res_tag_t          s1_tag_reg;
    c3x3_pkg::res_tag_t          s2_tag_reg;
    c3x3_pkg::res_tag_t          s3_tag_reg;
    c3x3_pkg::res_tag_t          out_tag_reg;

    logic [c3x3_pkg::WGT_W-1:0]          w_rd [c3x3_pkg::TAPS];
    logic [c3x3_pkg::BIAS_W-1:0]         b_rd;
    logic signed [c3x3_pkg::PROD_W-1:0]  prod_reg [c3x3_pkg::TAPS];
    logic signed [c3x3_pkg::BIAS_W-1:0]  bias_s2_reg;
    logic signed [c3x3_pkg::BIAS_W-1:0]  bias_s3_reg;
    logic signed [c3x3_pkg::PSUM_W-1:0]  psum_reg [3];
    logic signed [c3x3_pkg::CONV_W-1:0]  conv_reg;

    logic                               wr_weight;
    logic                               wr_bias;
    logic [c3x3_pkg::FILT_W-1:0]        wf;
    logic [c3x3_pkg::TAP_W-1:0]         wtap;
    logic [c3x3_pkg::FILT_W-1:0]        baddr;
    logic signed [c3x3_pkg::WGT_W-1:0]  wval;

    assign adv = !out_v_reg || !out_stall;

    assign status.win_full  = (row_reg >= c3x3_pkg::ROW_W'(2)) &&
                              (col_reg >= c3x3_pkg::COL_W'(2));
    assign status.pipe_busy = s1_v_reg || s2_v_reg;
    assign status.adv       = adv;

    assign row_m2 = row_reg - c3x3_pkg::ROW_W'(2);
    assign col_m2 = col_reg - c3x3_pkg::COL_W'(2);

    // coefficient write decode
    always_comb
    begin
        wr_weight = cmd.accept_coef && (int'(coef_index) < c3x3_pkg::WEIGHTS);
        wr_bias   = cmd.accept_coef && (int'(coef_index) >= c3x3_pkg::WEIGHTS) &&
                    (int'(coef_index) < c3x3_pkg::COEFS);
        wf        = c3x3_pkg::weight_filter(coef_index);
        wtap      = c3x3_pkg::TAP_W'(coef_index - 8'(wf) * 8'(c3x3_pkg::TAPS));
        baddr     = c3x3_pkg::FILT_W'(coef_index - 8'(c3x3_pkg::WEIGHTS));
        wval      = c3x3_pkg::sat_weight(coef_value);
    end

    // line store: [PW-1:0] is the older row, [2*PW-1:PW] the newer row
    c3x3_ram #(
        .WIDTH (2 * PW),
        .DEPTH (c3x3_pkg::IMG_W)
    ) u_line (
        .clk     (clk),
        .wr_en   (cmd.win_load),
        .wr_addr (col_reg),
        .wr_data ({px_reg, line_rd[2*PW-1:PW]}),
        .rd_en   (cmd.accept_pix),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    genvar t;
    generate
        for (t = 0; t < c3x3_pkg::TAPS; t++)
        begin : g_tap
            c3x3_ram #(
                .WIDTH (c3x3_pkg::WGT_W),
                .DEPTH (c3x3_pkg::FILTERS)
            ) u_wgt (
                .clk     (clk),
                .wr_en   (wr_weight && (wtap == c3x3_pkg::TAP_W'(t))),
                .wr_addr (wf),
                .wr_data (wval),
                .rd_en   (adv),
                .rd_addr (cmd.filt),
                .rd_data (w_rd[t])
            );

            // tap t = i + 3*j multiplies window row i, column j
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[t] <= $signed(w_rd[t]) *
                                   $signed({1'b0, win_reg[t % 3][t / 3]});
                end
            end
        end
    endgenerate

    c3x3_ram #(
        .WIDTH (c3x3_pkg::BIAS_W),
        .DEPTH (c3x3_pkg::FILTERS)
    ) u_bias (
        .clk     (clk),
        .wr_en   (wr_bias),
        .wr_addr (baddr),
        .wr_data (coef_value),
        .rd_en   (adv),
        .rd_addr (cmd.filt),
        .rd_data (b_rd)
    );

    // position counters and window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.win_load)
        begin
            if (col_reg == c3x3_pkg::COL_W'(c3x3_pkg::IMG_W - 1))
            begin
                col_reg <= '0;
                if (row_reg == c3x3_pkg::ROW_W'(c3x3_pkg::IMG_H - 1))
                begin
                    row_reg <= '0;
                end
                else
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_pix)
        begin
            px_reg <= pixel;
        end
        if (cmd.win_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= line_rd[PW-1:0];
            win_reg[1][2] <= line_rd[2*PW-1:PW];
            win_reg[2][2] <= px_reg;
            pos_row_reg   <= c3x3_pkg::TAG_W'(row_m2);
            pos_col_reg   <= c3x3_pkg::TAG_W'(col_m2);
        end
    end

    // MAC pipeline: weight read, multiply, partial sums, final sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg  <= cmd.issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            out_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg.filt <= cmd.filt;
            s1_tag_reg.row  <= pos_row_reg;
            s1_tag_reg.col  <= pos_col_reg;
            s1_tag_reg.last <= cmd.last;
            s2_tag_reg      <= s1_tag_reg;
            s3_tag_reg      <= s2_tag_reg;
            out_tag_reg     <= s3_tag_reg;
            bias_s2_reg     <= $signed(b_rd);
            bias_s3_reg     <= bias_s2_reg;
            for (int g = 0; g < 3; g++)
            begin
                psum_reg[g] <= c3x3_pkg::PSUM_W'(prod_reg[3*g]) +
                               c3x3_pkg::PSUM_W'(prod_reg[3*g+1]) +
                               c3x3_pkg::PSUM_W'(prod_reg[3*g+2]);
            end
            conv_reg <= c3x3_pkg::CONV_W'(psum_reg[0]) +
                        c3x3_pkg::CONV_W'(psum_reg[1]) +
                        c3x3_pkg::CONV_W'(psum_reg[2]) +
                        c3x3_pkg::CONV_W'(bias_s3_reg);
        end
    end

    assign out_valid    = out_v_reg;
    assign filter_index = 4'(out_tag_reg.filt);
    assign out_row      = out_tag_reg.row;
    assign out_col      = out_tag_reg.col;
    assign conv_value   = conv_reg;
    assign last         = out_tag_reg.last;

endmodule

@@ rtl/conv3x3_multi_filter_layer_top.sv @@
// 3x3 valid convolution with bias over a streamed 12x12 image, 16 filters.
// A pixel item (kind 0) that completes a 3x3 window yields 16 results, one per
// filter, in filter order with last set on filter 15; other pixels yield none.
// A coefficient item (kind 1) writes weight filter*9+i+3*j (saturated to 16
// bits, Q4.12) for index 0..143 or the bias of filter index-144 (Q12.12) for
// 144..159; larger indexes are ignored. Results are Q20.12 and never overflow.
// Sequencing: a coefficient item is taken in IDLE, a pixel with no window also in
// LOAD, one with a full window then in ISSUE at one filter's nine weights per cycle
// unless the output stalls; new input waits until the read and multiply stages empty.
// Output back-pressure freezes the MAC pipeline. All coefficients must be
// written before the first full window. Depends on c3x3_pkg, c3x3_ctrl, c3x3_dp.
module conv3x3_multi_filter_layer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                kind,
    input  logic [c3x3_pkg::PIX_W-1:0]          pixel,
    input  logic [7:0]                          coef_index,
    input  logic signed [c3x3_pkg::BIAS_W-1:0]  coef_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [3:0]                          filter_index,
    output logic [3:0]                          out_row,
    output logic [3:0]                          out_col,
    output logic signed [c3x3_pkg::CONV_W-1:0]  conv_value,
    output logic                                last
);

    c3x3_pkg::ctrl_cmd_t  cmd;
    c3x3_pkg::dp_status_t status;

    c3x3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    c3x3_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .pixel        (pixel),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filter_index (filter_index),
        .out_row      (out_row),
        .out_col      (out_col),
        .conv_value   (conv_value),
        .last         (last)
    );

endmodule
